/* sv/tqe_pkg.sv */
// Package for the timer queue expiry block.
// Holds field widths, result kind codes and the controller/datapath structs.
`default_nettype none
package tqe_pkg;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned TIME_W  = 63;
  localparam int unsigned IVL_W   = 32;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned IN_DW   = 168;
  localparam int unsigned OUT_DW  = 136;

  localparam int unsigned MAX_EXPIRE = 16;
  localparam int unsigned CNT_W      = $clog2(MAX_EXPIRE + 1);

  localparam logic [CFG_W-1:0] MIN_ARM_RST = CFG_W'(100);

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FULL = 2'd3;

  typedef struct packed {
    logic              capture;
    logic              scan_start;
    logic              emit;
    logic [KIND_W-1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_tick;
    logic best_found;
    logic free_found;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* sv/tqe_ctrl.sv */
// Controller for the timer queue expiry block.
// Sequences scans, expiry emission and status results; uses tqe_pkg.
`default_nettype none
module tqe_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  tqe_pkg::sts_t      sts_i,
  output tqe_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [tqe_pkg::CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture    = 1'b1;
          cmd_o.scan_start = 1'b1;
          cnt_d            = '0;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!sts_i.is_tick) begin
            cmd_o.kind = sts_i.free_found ? tqe_pkg::KIND_ACK : tqe_pkg::KIND_FULL;
            state_d    = S_IDLE;
          end else if (sts_i.best_found &&
                       (cnt_q < tqe_pkg::CNT_W'(tqe_pkg::MAX_EXPIRE))) begin
            cmd_o.kind       = tqe_pkg::KIND_EXP;
            cmd_o.scan_start = 1'b1;
            cnt_d            = cnt_q + 1'b1;
            state_d          = S_SCAN;
          end else begin
            cmd_o.kind = tqe_pkg::KIND_DONE;
            state_d    = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* sv/tqe_dp.sv */
// Datapath for the timer queue expiry block: slot memories, scan unit,
// re-arm logic and the result register. Uses tqe_pkg.
`default_nettype none
module tqe_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  tqe_pkg::cmd_t                       cmd_i,
  output tqe_pkg::sts_t                       sts_o,
  input  wire logic                           in_cmd_i,
  input  wire logic [tqe_pkg::ID_W-1:0]       in_id_i,
  input  wire logic [tqe_pkg::TIME_W-1:0]     in_when_i,
  input  wire logic [tqe_pkg::IVL_W-1:0]      in_ivl_i,
  input  wire logic [tqe_pkg::TIME_W-1:0]     in_now_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [tqe_pkg::CFG_W-1:0]      cfg_wdata_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [tqe_pkg::KIND_W-1:0]          out_kind_o,
  output logic [tqe_pkg::ID_W-1:0]            out_id_o,
  output logic                                out_ec_o,
  output logic                                out_hp_o,
  output logic [tqe_pkg::TIME_W-1:0]          out_nd_o,
  output logic [tqe_pkg::TIME_W-1:0]          out_ad_o,
  output logic                                out_last_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned TW = tqe_pkg::TIME_W;

  logic [TW-1:0]               dl_mem [CAPACITY];
  logic [tqe_pkg::IVL_W-1:0]   iv_mem [CAPACITY];
  logic [tqe_pkg::ID_W-1:0]    id_mem [CAPACITY];

  logic [CAPACITY-1:0]         valid_q, taken_q;
  logic [tqe_pkg::CFG_W-1:0]   min_arm_q;
  logic [TW-1:0]               last_now_q;

  logic                        cmd_q;
  logic [tqe_pkg::ID_W-1:0]    id_q;
  logic [TW-1:0]               when_q, now_q;
  logic [tqe_pkg::IVL_W-1:0]   ivl_q;

  logic                        busy_q, rd_act_q, done_q;
  logic [IW-1:0]               addr_q, rd_idx_q;
  logic [TW-1:0]               rd_dl_q;
  logic [tqe_pkg::IVL_W-1:0]   rd_iv_q;
  logic [tqe_pkg::ID_W-1:0]    rd_id_q;

  logic                        any_q, best_q, free_q;
  logic [TW-1:0]               min_q, best_dl_q;
  logic [tqe_pkg::ID_W-1:0]    best_id_q;
  logic [tqe_pkg::IVL_W-1:0]   best_iv_q;
  logic [IW-1:0]               best_idx_q, free_idx_q;

  logic                        out_valid_q;

  logic                        rd_v, rd_better;
  logic [TW:0]                 sum, diff;
  logic [TW-1:0]               rearm_dl;
  logic                        ec, hp;
  logic [TW-1:0]               nd, ad;
  logic                        wr_add, wr_exp;

  assign rd_v = rd_act_q && valid_q[rd_idx_q];
  assign rd_better = !best_q || (rd_dl_q < best_dl_q) ||
                     ((rd_dl_q == best_dl_q) && (rd_id_q < best_id_q));

  assign sum      = {1'b0, now_q} + {{(TW + 1 - tqe_pkg::IVL_W){1'b0}}, best_iv_q};
  assign rearm_dl = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

  assign wr_add = cmd_i.emit && (cmd_i.kind == tqe_pkg::KIND_ACK);
  assign wr_exp = cmd_i.emit && (cmd_i.kind == tqe_pkg::KIND_EXP);

  always_comb begin
    ec = 1'b0;
    hp = any_q;
    nd = any_q ? min_q : '0;
    if (cmd_i.kind == tqe_pkg::KIND_ACK) begin
      ec = !any_q || (when_q < min_q);
      hp = 1'b1;
      nd = ec ? when_q : min_q;
    end
    diff = {1'b0, nd} - {1'b0, last_now_q};
    if (!hp) begin
      ad = '0;
    end else if (diff[TW] ||
                 (diff[TW-1:0] < {{(TW - tqe_pkg::CFG_W){1'b0}}, min_arm_q})) begin
      ad = {{(TW - tqe_pkg::CFG_W){1'b0}}, min_arm_q};
    end else begin
      ad = diff[TW-1:0];
    end
  end

  assign sts_o.scan_done  = done_q;
  assign sts_o.is_tick    = (cmd_q == tqe_pkg::CMD_TICK);
  assign sts_o.best_found = best_q;
  assign sts_o.free_found = free_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rd_dl_q  <= dl_mem[addr_q];
      rd_iv_q  <= iv_mem[addr_q];
      rd_id_q  <= id_mem[addr_q];
    end
    if (wr_add) begin
      dl_mem[free_idx_q] <= when_q;
      iv_mem[free_idx_q] <= ivl_q;
      id_mem[free_idx_q] <= id_q;
    end else if (wr_exp && (best_iv_q != '0)) begin
      dl_mem[best_idx_q] <= rearm_dl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= in_cmd_i;
      id_q   <= in_id_i;
      when_q <= in_when_i;
      ivl_q  <= in_ivl_i;
      now_q  <= in_now_i;
    end
    if (cmd_i.scan_start) begin
      min_q <= '0;
    end else if (rd_v && (!any_q || (rd_dl_q < min_q))) begin
      min_q <= rd_dl_q;
    end
    if (rd_v && !taken_q[rd_idx_q] && (rd_dl_q <= now_q) && rd_better) begin
      best_dl_q  <= rd_dl_q;
      best_id_q  <= rd_id_q;
      best_iv_q  <= rd_iv_q;
      best_idx_q <= rd_idx_q;
    end
    if (rd_act_q && !valid_q[rd_idx_q] && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.emit) begin
      out_kind_o <= cmd_i.kind;
      out_id_o   <= (cmd_i.kind == tqe_pkg::KIND_EXP) ? best_id_q : '0;
      out_ec_o   <= ec;
      out_hp_o   <= (cmd_i.kind == tqe_pkg::KIND_EXP) ? 1'b0 : hp;
      out_nd_o   <= (cmd_i.kind == tqe_pkg::KIND_EXP) ? '0 : nd;
      out_ad_o   <= (cmd_i.kind == tqe_pkg::KIND_EXP) ? '0 : ad;
      out_last_o <= (cmd_i.kind != tqe_pkg::KIND_EXP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      taken_q     <= '0;
      min_arm_q   <= tqe_pkg::MIN_ARM_RST;
      last_now_q  <= '0;
      busy_q      <= 1'b0;
      rd_act_q    <= 1'b0;
      done_q      <= 1'b0;
      addr_q      <= '0;
      rd_idx_q    <= '0;
      any_q       <= 1'b0;
      best_q      <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_arm_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        taken_q <= '0;
        if (in_cmd_i == tqe_pkg::CMD_TICK) begin
          last_now_q <= in_now_i;
        end
      end
      if (wr_add) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (wr_exp) begin
        taken_q[best_idx_q] <= 1'b1;
        if (best_iv_q == '0) begin
          valid_q[best_idx_q] <= 1'b0;
        end
      end
      rd_act_q <= busy_q;
      rd_idx_q <= addr_q;
      done_q   <= rd_act_q && (rd_idx_q == IW'(CAPACITY - 1));
      if (cmd_i.scan_start) begin
        busy_q <= 1'b1;
        addr_q <= '0;
        any_q  <= 1'b0;
        best_q <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (busy_q) begin
          if (addr_q == IW'(CAPACITY - 1)) begin
            busy_q <= 1'b0;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        if (rd_v) begin
          any_q <= 1'b1;
        end
        if (rd_v && !taken_q[rd_idx_q] && (rd_dl_q <= now_q)) begin
          best_q <= 1'b1;
        end
        if (rd_act_q && !valid_q[rd_idx_q]) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* sv/timer_queue_expiry.sv */
// Timer queue expiry: an add runs one slot scan and emits its one result; the
// next input transfer can be taken in the cycle after that result is emitted.
// A tick runs one slot scan per expired timer (at most 16) plus a final one.
// Each scan reads one slot per cycle, and output stalls hold the block longer.
// Reset clears the slot valid bits and reference time at once and sets the
// minimum arm delay to 100; there is no clearing pass.
`default_nettype none
module timer_queue_expiry #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // timer_id, expire_time, repeat_interval, now_time, zero pad
  input  wire logic [tqe_pkg::IN_DW-1:0]     s_axis_tdata,
  // command
  input  wire logic [0:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // expired_id, earliest_changed, has_pending, next_deadline, arm_delay
  output logic [tqe_pkg::OUT_DW-1:0]         m_axis_tdata,
  // kind
  output logic [tqe_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                               m_axis_tlast,
  input  wire logic                          cfg_we_i,
  input  wire logic [tqe_pkg::CFG_W-1:0]     cfg_wdata_i
);

  tqe_pkg::cmd_t                cmd;
  tqe_pkg::sts_t                sts;
  logic [tqe_pkg::ID_W-1:0]     out_id;
  logic                         out_ec, out_hp;
  logic [tqe_pkg::TIME_W-1:0]   out_nd, out_ad;

  tqe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tqe_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_cmd_i    (s_axis_tuser[0]),
    .in_id_i     (s_axis_tdata[7:0]),
    .in_when_i   (s_axis_tdata[70:8]),
    .in_ivl_i    (s_axis_tdata[102:71]),
    .in_now_i    (s_axis_tdata[165:103]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_id_o    (out_id),
    .out_ec_o    (out_ec),
    .out_hp_o    (out_hp),
    .out_nd_o    (out_nd),
    .out_ad_o    (out_ad),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_ad, out_nd, out_hp, out_ec, out_id};

`ifndef SYNTHESIS
  a_exp_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == tqe_pkg::KIND_EXP)) |-> !m_axis_tlast)
    else $error("expired result marked last");

  a_add_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((m_axis_tuser == tqe_pkg::KIND_ACK) ||
                       (m_axis_tuser == tqe_pkg::KIND_FULL))) |-> m_axis_tlast)
    else $error("add result not marked last");

  a_idle_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_hp) |-> ((out_nd == '0) && (out_ad == '0)))
    else $error("status fields set with nothing pending");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.scan_done |-> !s_axis_tready)
    else $error("input accepted during a scan");
`endif

endmodule
`default_nettype wire

/* tb/timer_queue_expiry_tb.sv */
// Self-checking testbench for the timer queue expiry block.
// Drives add and tick transfers on the input stream, predicts every result in a
// small scoreboard class and checks the output stream; depends on tqe_pkg.
`default_nettype none
module timer_queue_expiry_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 16;
  localparam logic [tqe_pkg::TIME_W-1:0] TMAX = {tqe_pkg::TIME_W{1'b1}};

  typedef struct packed {
    logic [tqe_pkg::KIND_W-1:0] kind;
    logic [tqe_pkg::ID_W-1:0]   id;
    logic                       ec;
    logic                       hp;
    logic [tqe_pkg::TIME_W-1:0] nd;
    logic [tqe_pkg::TIME_W-1:0] ad;
    logic                       lst;
  } timer_res_t;

  class timer_scoreboard;
    logic                       valid [SLOTS];
    logic [tqe_pkg::TIME_W-1:0] deadline [SLOTS];
    logic [tqe_pkg::IVL_W-1:0]  interval [SLOTS];
    logic [tqe_pkg::ID_W-1:0]   tid [SLOTS];
    logic [tqe_pkg::TIME_W-1:0] ref_now;
    logic [tqe_pkg::CFG_W-1:0]  min_arm;
    timer_res_t                 pending_q[$];
    int                         errors;

    function new();
      foreach (valid[i]) valid[i] = 1'b0;
      ref_now = '0;
      min_arm = tqe_pkg::MIN_ARM_RST;
      errors  = 0;
    endfunction

    function bit ordered_first(int a, int b);
      if (deadline[a] != deadline[b]) return deadline[a] < deadline[b];
      if (tid[a] != tid[b]) return tid[a] < tid[b];
      return a < b;
    endfunction

    function void push_status(logic [tqe_pkg::KIND_W-1:0] kind, logic ec);
      timer_res_t r;
      bit any;
      logic [tqe_pkg::TIME_W-1:0] dl;
      any = 0;
      dl  = '0;
      r   = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (valid[i] && (!any || deadline[i] < dl)) begin
          dl  = deadline[i];
          any = 1;
        end
      end
      r.kind = kind;
      r.ec   = ec;
      r.lst  = 1'b1;
      if (any) begin
        r.hp = 1'b1;
        r.nd = dl;
        r.ad = (dl > ref_now) ? dl - ref_now : '0;
        if (r.ad < tqe_pkg::TIME_W'(min_arm)) r.ad = tqe_pkg::TIME_W'(min_arm);
      end
      pending_q.push_back(r);
    endfunction

    function void note_input(logic cmd, logic [tqe_pkg::ID_W-1:0] id,
                             logic [tqe_pkg::TIME_W-1:0] when,
                             logic [tqe_pkg::IVL_W-1:0] ivl,
                             logic [tqe_pkg::TIME_W-1:0] now);
      int free_slot;
      int best;
      int n;
      int order [$];
      bit taken [SLOTS];
      bit any;
      logic [tqe_pkg::TIME_W-1:0] dl;
      logic [tqe_pkg::TIME_W:0] sum;
      timer_res_t r;
      if (cmd == tqe_pkg::CMD_ADD) begin
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!valid[i]) free_slot = i;
        if (free_slot < 0) begin
          push_status(tqe_pkg::KIND_FULL, 1'b0);
          return;
        end
        any = 0;
        dl  = '0;
        foreach (valid[i])
          if (valid[i] && (!any || deadline[i] < dl)) begin
            dl  = deadline[i];
            any = 1;
          end
        valid[free_slot]    = 1'b1;
        deadline[free_slot] = when;
        interval[free_slot] = ivl;
        tid[free_slot]      = id;
        push_status(tqe_pkg::KIND_ACK, !any || when < dl);
        return;
      end
      foreach (taken[i]) taken[i] = 0;
      ref_now = now;
      n = 0;
      while (n < tqe_pkg::MAX_EXPIRE) begin
        best = -1;
        for (int i = 0; i < SLOTS; i++)
          if (valid[i] && !taken[i] && deadline[i] <= now &&
              (best < 0 || ordered_first(i, best)))
            best = i;
        if (best < 0) break;
        taken[best] = 1;
        order.push_back(best);
        r      = '0;
        r.kind = tqe_pkg::KIND_EXP;
        r.id   = tid[best];
        pending_q.push_back(r);
        n++;
      end
      foreach (order[k]) begin
        if (interval[order[k]] == '0) begin
          valid[order[k]] = 1'b0;
        end else begin
          sum = {1'b0, now} + (tqe_pkg::TIME_W + 1)'(interval[order[k]]);
          deadline[order[k]] = sum[tqe_pkg::TIME_W] ? TMAX : sum[tqe_pkg::TIME_W-1:0];
        end
      end
      push_status(tqe_pkg::KIND_DONE, 1'b0);
    endfunction

    function void check_result(timer_res_t got);
      timer_res_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [tqe_pkg::IN_DW-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [tqe_pkg::OUT_DW-1:0] m_axis_tdata;
  logic [tqe_pkg::KIND_W-1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [tqe_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  timer_scoreboard sb = new();
  logic [tqe_pkg::TIME_W-1:0] now_cur = '0;
  bit long_hold = 0;
  int unsigned cycles = 0;

  timer_queue_expiry #(.CAPACITY(SLOTS)) uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    timer_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.id   = m_axis_tdata[7:0];
      got.ec   = m_axis_tdata[8];
      got.hp   = m_axis_tdata[9];
      got.nd   = m_axis_tdata[72:10];
      got.ad   = m_axis_tdata[135:73];
      got.lst  = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // receiver: random stalls, one long hold-off on request
  always begin
    int unsigned len;
    @(negedge clk_i);
    if (long_hold) begin
      m_axis_tready = 1'b0;
      repeat (900) @(negedge clk_i);
      long_hold = 0;
    end
    if ($urandom_range(99) < 70) begin
      m_axis_tready = 1'b1;
    end else begin
      len = ($urandom_range(99) < 6) ? $urandom_range(60, 20) : $urandom_range(3, 1);
      m_axis_tready = 1'b0;
      repeat (len - 1) @(negedge clk_i);
    end
  end

  function automatic logic [tqe_pkg::TIME_W-1:0] rand_time();
    return tqe_pkg::TIME_W'({$urandom, $urandom});
  endfunction

  function automatic logic [tqe_pkg::ID_W-1:0] rand_id();
    return tqe_pkg::ID_W'($urandom);
  endfunction

  task automatic send_item(logic cmd, logic [tqe_pkg::ID_W-1:0] id,
                           logic [tqe_pkg::TIME_W-1:0] when,
                           logic [tqe_pkg::IVL_W-1:0] ivl,
                           logic [tqe_pkg::TIME_W-1:0] now);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {2'b00, now, ivl, when, id};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, id, when, ivl, now);
  endtask

  task automatic sender_gap();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(99);
    if (r < 60) return;
    len = (r < 95) ? $urandom_range(4, 1) : $urandom_range(80, 20);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (len - 1) @(negedge clk_i);
  endtask

  task automatic drain_and_config(logic [tqe_pkg::CFG_W-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (sb.pending_q.size() == 0);
    repeat (40) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.min_arm = value;
  endtask

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) begin
      send_item(tqe_pkg::CMD_TICK, rand_id(), rand_time(), $urandom, rand_time());
    end else if (r < 10) begin
      send_item(tqe_pkg::CMD_ADD, rand_id(), rand_time(),
                ($urandom_range(1) ? $urandom : 0), rand_time());
    end else if (r < 58) begin
      send_item(tqe_pkg::CMD_ADD, rand_id(), now_cur + $urandom_range(3000),
                ($urandom_range(1) ? $urandom_range(2000, 1) : 0), rand_time());
    end else begin
      now_cur = now_cur + $urandom_range(1500);
      send_item(tqe_pkg::CMD_TICK, rand_id(), rand_time(), $urandom, now_cur);
    end
    sender_gap();
  endtask

  initial begin
    logic [tqe_pkg::CFG_W-1:0] cfgs [5];
    cfgs = '{tqe_pkg::CFG_W'(0), tqe_pkg::CFG_W'(1000000), tqe_pkg::CFG_W'(1),
             tqe_pkg::CFG_W'($urandom_range(1000000)),
             tqe_pkg::CFG_W'($urandom_range(5000))};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    drain_and_config(tqe_pkg::CFG_W'(100));

    send_item(tqe_pkg::CMD_ADD, 8'd0, '0, '0, '0);
    send_item(tqe_pkg::CMD_ADD, 8'd255, TMAX, {tqe_pkg::IVL_W{1'b1}}, TMAX);
    send_item(tqe_pkg::CMD_TICK, '0, '0, '0, '0);
    send_item(tqe_pkg::CMD_ADD, 8'd5, 63'd1000, '0, '0);
    send_item(tqe_pkg::CMD_ADD, 8'd5, 63'd1000, '0, '0);
    send_item(tqe_pkg::CMD_ADD, 8'd3, 63'd1000, 32'd500, '0);
    send_item(tqe_pkg::CMD_TICK, '0, '0, '0, 63'd2000);
    send_item(tqe_pkg::CMD_TICK, '0, '0, '0, TMAX - 63'd10);
    send_item(tqe_pkg::CMD_TICK, '0, '0, '0, 63'd100);
    for (int i = 0; i < 15; i++)
      send_item(tqe_pkg::CMD_ADD, tqe_pkg::ID_W'(i * 17), TMAX - tqe_pkg::TIME_W'(i),
                (i % 2) ? tqe_pkg::IVL_W'(i) : '0, '0);
    send_item(tqe_pkg::CMD_TICK, '0, '0, '0, TMAX);
    now_cur = 63'd10000;

    for (int p = 0; p < 5; p++) begin
      drain_and_config(cfgs[p]);
      send_item(tqe_pkg::CMD_TICK, '0, '0, '0, TMAX);
      if (p == 1) long_hold = 1;
      for (int k = 0; k < 48; k++) random_item();
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (sb.pending_q.size() == 0);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
sv/tqe_pkg.sv
sv/tqe_ctrl.sv
sv/tqe_dp.sv
sv/timer_queue_expiry.sv
tb/timer_queue_expiry_tb.sv
